// ===== src/first_fit_allocator_compacting_macros.svh =====
// Assertion macros for the first-fit allocator with compaction.
// Depends on nothing; taken in by the files that carry assertions.
`ifndef FIRST_FIT_ALLOCATOR_COMPACTING_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_COMPACTING_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain invariant, checked at every clock edge outside reset.
`define FFAC_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ffac assertion failed");
// Same-cycle implication.
`define FFAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffac assertion failed");
// Next-cycle implication.
`define FFAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffac assertion failed");
`else
`define FFAC_ASSERT(lbl, clk, rst_n, expr)
`define FFAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FFAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ffac_pkg.sv =====
// Package for the first-fit allocator with compaction: field widths, codes and beat types.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ffac_pkg;

    localparam int CELLS_DEF       = 128;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int OP_W  = 2;
    localparam int AMT_W = 8;
    localparam int TGT_W = 16;
    localparam int ST_W  = 2;
    localparam int ACT_W = 8;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 8'd128;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_ILLEGAL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [AMT_W-1:0] amount;
        logic [TGT_W-1:0] target_handle;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [TGT_W-1:0] granted_handle;
    } rsp_t;

    typedef logic [ACT_W-1:0] cfg_t;

endpackage

// ===== src/ffac_channels.sv =====
// Valid/ready channel interfaces for request, response and configuration beats.
// Depends on ffac_pkg.
`timescale 1ns / 1ps

interface ffac_req_if;
    import ffac_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffac_rsp_if;
    import ffac_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffac_cfg_if;
    import ffac_pkg::*;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/first_fit_allocator_compacting.sv =====
// Allocate scans the usable cells for a free run, then writes the granted cells; erase
// sweeps every cell; defragment runs a copy sweep, then a wipe of the cells above it.
// Throughput: one beat at a time, set by the single-port cell store read once per cycle.
// Reset: a clearing pass writes every cell free, with requests held off;
// configuration beats are taken throughout. The next handle resets to 1, active cells to 128.
`timescale 1ns / 1ps
`include "first_fit_allocator_compacting_macros.svh"

module first_fit_allocator_compacting #(
    parameter int CELLS       = ffac_pkg::CELLS_DEF,
    parameter int HANDLE_BITS = ffac_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ffac_req_if.sink    req,
    ffac_rsp_if.source  rsp,
    ffac_cfg_if.sink    cfg
);
    import ffac_pkg::*;

    // Address width of the store, and a count width able to hold CELLS itself.
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(CELLS + 1);
    // Common width for comparing the 8-bit amount and register with cell counts.
    localparam int LW = (CW > AMT_W) ? CW : AMT_W;
    // Common width for comparing 16-bit handle fields with stored handles.
    localparam int TW = (HANDLE_BITS > TGT_W) ? HANDLE_BITS : TGT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_WIPE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // The cell store: one owner handle per cell, zero meaning free. It has a single
    // write port and a single registered read port, and the whole sequencer below is
    // built around reading one cell per cycle from it.
    logic [HANDLE_BITS-1:0] cell_mem [CELLS];
    logic [HANDLE_BITS-1:0] rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [HANDLE_BITS-1:0] wr_data;
    logic [AW-1:0]          rd_addr;

    logic [2:0]             state_reg, state_next;
    logic [ACT_W-1:0]       active_reg;
    logic [HANDLE_BITS-1:0] next_handle_reg, next_handle_next;

    // Latched request fields.
    logic [OP_W-1:0]        op_reg, op_next;
    logic [AMT_W-1:0]       amount_reg, amount_next;
    logic [TGT_W-1:0]       target_reg, target_next;

    // Sweep control: idx is the cell being read, chk the cell whose data has arrived.
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   pend_reg, pend_next;
    logic [CW-1:0]          scan_lim_reg, scan_lim_next;
    logic [CW-1:0]          run_reg, run_next;
    logic [CW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]          fill_cnt_reg, fill_cnt_next;
    logic                   live_reg, live_next;

    // Result staging and the output register.
    logic [ST_W-1:0]        res_status_reg, res_status_next;
    logic [TGT_W-1:0]       res_handle_reg, res_handle_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_data_reg, out_data_next;

    // Derived values.
    logic [LW-1:0]          act_lw;
    logic [LW-1:0]          lim_lw;
    logic [LW-1:0]          amount_lw;
    logic [CW-1:0]          amt_cw;
    logic [TW-1:0]          handle_tw;
    logic [TW-1:0]          target_tw;
    logic [TW-1:0]          data_tw;
    logic                   issue;
    logic                   req_acc;

    assign req.ready   = (state_reg == S_IDLE);
    assign req_acc     = req.valid && req.ready;
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.data    = out_data_reg;

    // Usable cells: a register value of zero acts as one, anything above CELLS as CELLS.
    assign act_lw    = LW'(active_reg);
    assign lim_lw    = (active_reg == '0) ? LW'(1)
                     : ((act_lw > LW'(CELLS)) ? LW'(CELLS) : act_lw);
    assign amount_lw = LW'(req.data.amount);
    // The amount has been checked against the usable cells before it is used here.
    assign amt_cw    = CW'(amount_reg);
    assign handle_tw = TW'(next_handle_reg);
    assign target_tw = TW'(target_reg);
    assign data_tw   = TW'(rd_data_reg);
    assign issue     = (idx_reg < scan_lim_reg);
    assign rd_addr   = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cell_mem[rd_addr];
    end

    always_comb
    begin
        state_next       = state_reg;
        next_handle_next = next_handle_reg;
        op_next          = op_reg;
        amount_next      = amount_reg;
        target_next      = target_reg;
        idx_next         = idx_reg;
        chk_idx_next     = chk_idx_reg;
        pend_next        = 1'b0;
        scan_lim_next    = scan_lim_reg;
        run_next         = run_reg;
        wr_ptr_next      = wr_ptr_reg;
        fill_cnt_next    = fill_cnt_reg;
        live_next        = live_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        wr_addr          = idx_reg[AW-1:0];
        wr_data          = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == CW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_acc)
                begin
                    op_next         = req.data.operation;
                    amount_next     = req.data.amount;
                    target_next     = req.data.target_handle;
                    idx_next        = '0;
                    run_next        = '0;
                    wr_ptr_next     = '0;
                    live_next       = 1'b0;
                    scan_lim_next   = CW'(CELLS);
                    res_status_next = ST_DONE;
                    res_handle_next = '0;
                    priority if (req.data.operation == OP_ALLOC)
                    begin
                        if (req.data.amount == '0 || amount_lw > lim_lw
                            || next_handle_reg == '0)
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            scan_lim_next = lim_lw[CW-1:0];
                            state_next    = S_SCAN;
                        end
                    end
                    else if (req.data.operation == OP_ERASE)
                    begin
                        if (req.data.target_handle == '0)
                        begin
                            res_status_next = ST_ILLEGAL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (req.data.operation == OP_DEFRAG)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous cell's data is examined.
                if (issue)
                begin
                    pend_next    = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    chk_idx_next = idx_reg;
                end
                if (pend_reg)
                begin
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (rd_data_reg == '0)
                            begin
                                run_next = run_reg + CW'(1);
                                if (run_reg + CW'(1) == amt_cw)
                                begin
                                    wr_ptr_next   = chk_idx_reg + CW'(1) - amt_cw;
                                    fill_cnt_next = amt_cw;
                                    pend_next     = 1'b0;
                                    state_next    = S_FILL;
                                end
                            end
                            else
                            begin
                                run_next = '0;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (data_tw == target_tw)
                            begin
                                mem_we    = 1'b1;
                                wr_addr   = chk_idx_reg[AW-1:0];
                                wr_data   = '0;
                                live_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Compaction: the write pointer never passes the cell read.
                            if (rd_data_reg != '0)
                            begin
                                mem_we      = 1'b1;
                                wr_addr     = wr_ptr_reg[AW-1:0];
                                wr_data     = rd_data_reg;
                                wr_ptr_next = wr_ptr_reg + CW'(1);
                            end
                        end
                    endcase
                end
                else if (!issue)
                begin
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                        OP_ERASE:
                        begin
                            res_status_next = live_reg ? ST_DONE : ST_ILLEGAL;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_WIPE;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                mem_we        = 1'b1;
                wr_addr       = wr_ptr_reg[AW-1:0];
                wr_data       = next_handle_reg;
                wr_ptr_next   = wr_ptr_reg + CW'(1);
                fill_cnt_next = fill_cnt_reg - CW'(1);
                if (fill_cnt_reg == CW'(1))
                begin
                    res_status_next  = ST_DONE;
                    res_handle_next  = handle_tw[TGT_W-1:0];
                    next_handle_next = next_handle_reg + HANDLE_BITS'(1);
                    state_next       = S_DONE;
                end
            end

            S_WIPE:
            begin
                // Free everything above the compacted blocks.
                if (wr_ptr_reg == CW'(CELLS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    wr_addr     = wr_ptr_reg[AW-1:0];
                    wr_data     = '0;
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
            end

            S_DONE:
            begin
                // Hand the status to the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = res_status_reg;
                    out_data_next.granted_handle = res_handle_reg;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            active_reg      <= ACTIVE_RESET;
            next_handle_reg <= HANDLE_BITS'(1);
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_handle_reg <= next_handle_next;
            idx_reg         <= idx_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                active_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        amount_reg     <= amount_next;
        target_reg     <= target_next;
        chk_idx_reg    <= chk_idx_next;
        scan_lim_reg   <= scan_lim_next;
        run_reg        <= run_next;
        wr_ptr_reg     <= wr_ptr_next;
        fill_cnt_reg   <= fill_cnt_next;
        live_reg       <= live_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_data_reg   <= out_data_next;
    end

    // Compaction must never write above the cell it is reading, or it would overwrite
    // cells that have not yet been moved.
    `FFAC_ASSERT_IMP(a_defrag_ptr, clk, rst_n, state_reg == S_SCAN && op_reg == OP_DEFRAG, wr_ptr_reg <= idx_reg)
    // Every store write lands inside the store.
    `FFAC_ASSERT_IMP(a_wr_range, clk, rst_n, mem_we, CW'(wr_addr) < CW'(CELLS))
    // A granted handle is only ever reported with a done status.
    `FFAC_ASSERT_IMP(a_grant_done, clk, rst_n, rsp.valid && rsp.data.granted_handle != '0, rsp.data.status == ST_DONE)
    // The handle counter only moves at the end of a fill sweep.
    `FFAC_ASSERT_NXT(a_handle_step, clk, rst_n, state_reg != S_FILL, $stable(next_handle_reg))

endmodule
